>>> hdl/ndsu_pkg.sv
// Package: shared types, opcodes and register-file sizing for the division-step unit.
`default_nettype none
package ndsu_pkg;

   localparam int REG_COUNT = 16;
   localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_DIV0U = 3'd2,
      OP_DIV0S = 3'd3,
      OP_DIV1  = 3'd4,
      OP_ROTL  = 3'd5
   } opcode_type;

   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  reg_n;
      logic [3:0]  reg_m;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [31:0] reg_value;
      logic        m_bit;
      logic        q_bit;
      logic        t_bit;
   } rsp_type;

   typedef struct packed {
      logic m;
      logic q;
      logic t;
   } flags_type;

   typedef struct packed {
      logic        wr_en;
      logic [31:0] rn;
      flags_type   flags;
   } alu_out_type;

   // Reduce a 4-bit register index into the file by repeated subtraction.
   function automatic reg_idx_type pick_reg(input logic [3:0] idx);
      logic [4:0] v;
      v = {1'b0, idx};
      for (int i = 0; i < 8; i++) begin
         if (v >= 5'(REG_COUNT)) begin
            v = v - 5'(REG_COUNT);
         end
      end
      return v[REG_IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> hdl/ndsu_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module ndsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                              rd_data_a,
   output logic [WIDTH-1:0]                              rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

>>> hdl/ndsu_alu.sv
// Execute logic: computes new Rn and status bits for one operation.
`default_nettype none
module ndsu_alu (
   input  wire logic [2:0]          opcode,
   input  wire logic                same_reg,
   input  wire logic [31:0]         rn_val,
   input  wire logic [31:0]         rm_val,
   input  wire logic [31:0]         wr_val,
   input  wire ndsu_pkg::flags_type flags,
   output ndsu_pkg::alu_out_type    result
);
   import ndsu_pkg::*;

   logic [31:0] shifted;
   logic [31:0] divisor;
   logic [32:0] diff;
   logic [32:0] sum;
   logic        cb;
   logic        q_new;

   always_comb begin
      shifted = {rn_val[30:0], flags.t};
      // Rn shared with Rm: the divisor is the already shifted value
      divisor = same_reg ? shifted : rm_val;
      diff    = {1'b0, shifted} - {1'b0, divisor};
      sum     = {1'b0, shifted} + {1'b0, divisor};
      cb      = (flags.q == flags.m) ? diff[32] : sum[32];
      q_new   = rn_val[31] ^ cb ^ flags.m;

      result.wr_en = 1'b0;
      result.rn    = rn_val;
      result.flags = flags;
      case (opcode)
         OP_WRITE: begin
            result.wr_en = 1'b1;
            result.rn    = wr_val;
         end
         OP_DIV0U: begin
            result.flags = '0;
         end
         OP_DIV0S: begin
            result.flags.q = rn_val[31];
            result.flags.m = rm_val[31];
            result.flags.t = rn_val[31] ^ rm_val[31];
         end
         OP_DIV1: begin
            result.wr_en   = 1'b1;
            result.rn      = (flags.q == flags.m) ? diff[31:0] : sum[31:0];
            result.flags.q = q_new;
            result.flags.t = (q_new == flags.m);
         end
         OP_ROTL: begin
            result.wr_en   = 1'b1;
            result.rn      = {rn_val[30:0], rn_val[31]};
            result.flags.t = rn_val[31];
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/nonrestoring_division_step_unit_core.sv
// Top level: division-step unit with register file, status bits and two-stage pipeline.
//
//   channel | ports                               | moves
//   --------+-------------------------------------+-------------------------------
//   request | req_valid, req_ready, req_payload   | one operation per transfer
//   result  | rsp_valid, rsp_ready, rsp_payload   | Rn and M/Q/T after the operation
//
// One operation per cycle sustained while the result side keeps up; the register-file read
// lands with the input register, and the execute logic feeds the result register.
// A write in execute is forwarded to a read issued in the same cycle.
// Reset clears valid bits of the register file (unwritten registers read as zero) and M/Q/T.
// The request side stalls only while a result is held and the execute stage is full.
`default_nettype none
module nonrestoring_division_step_unit_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ndsu_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ndsu_pkg::rsp_type      rsp_payload
);
   import ndsu_pkg::*;

   logic                 accept;
   logic                 s1_move;
   logic                 s1_valid_ff, s1_valid_in;
   req_type              s1_req_ff;
   reg_idx_type          s1_n_ff, s1_m_ff;
   reg_idx_type          req_n, req_m;
   logic                 hit_n_ff, hit_m_ff;
   logic [31:0]          fwd_ff;
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   flags_type            flags_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff;
   logic [31:0]          rd_a, rd_b;
   logic [31:0]          rn_op, rm_op;
   alu_out_type          alu;

   assign req_n     = pick_reg(req_payload.reg_n);
   assign req_m     = pick_reg(req_payload.reg_m);
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   ndsu_ram #(
      .WIDTH(32),
      .DEPTH(REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (s1_move && alu.wr_en),
      .wr_addr   (s1_n_ff),
      .wr_data   (alu.rn),
      .rd_en     (accept),
      .rd_addr_a (req_n),
      .rd_addr_b (req_m),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // Pick forwarded, stored or reset value for each operand.
   always_comb begin
      rn_op = hit_n_ff ? fwd_ff : (valid_ff[s1_n_ff] ? rd_a : 32'd0);
      rm_op = hit_m_ff ? fwd_ff : (valid_ff[s1_m_ff] ? rd_b : 32'd0);
   end

   ndsu_alu u_alu (
      .opcode   (s1_req_ff.opcode),
      .same_reg (s1_n_ff == s1_m_ff),
      .rn_val   (rn_op),
      .rm_val   (rm_op),
      .wr_val   (s1_req_ff.write_value),
      .flags    (flags_ff),
      .result   (alu)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
      valid_in     = valid_ff;
      if (s1_move && alu.wr_en) begin
         valid_in[s1_n_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         if (s1_move) begin
            flags_ff <= alu.flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_payload;
         s1_n_ff   <= req_n;
         s1_m_ff   <= req_m;
         // Capture the write landing this cycle; the RAM read returns the old word.
         hit_n_ff  <= s1_move && alu.wr_en && (s1_n_ff == req_n);
         hit_m_ff  <= s1_move && alu.wr_en && (s1_n_ff == req_m);
         fwd_ff    <= alu.rn;
      end
      if (s1_move) begin
         rsp_ff.reg_value <= alu.rn;
         rsp_ff.m_bit     <= alu.flags.m;
         rsp_ff.q_bit     <= alu.flags.q;
         rsp_ff.t_bit     <= alu.flags.t;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready && s1_valid_ff))
      else $error("request side stalled without a held result");

   a_div0u_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_req_ff.opcode == OP_DIV0U) |=>
      (!rsp_payload.m_bit && !rsp_payload.q_bit && !rsp_payload.t_bit))
      else $error("DIV0U result carries a set status bit");

   a_read_returns_operand: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_req_ff.opcode == OP_READ) |=>
      (rsp_payload.reg_value == $past(rn_op)))
      else $error("read result differs from the register operand");

   a_flags_follow_result: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (flags_ff.t == rsp_payload.t_bit && flags_ff.m == rsp_payload.m_bit))
      else $error("status bits out of step with the result");

endmodule
`default_nettype wire

>>> tb/sv/nonrestoring_division_step_unit_core_test.sv
// Testbench for the division-step unit: random operation streams checked against a predictor.
`timescale 1ns / 100ps
module nonrestoring_division_step_unit_core_test;
   import ndsu_pkg::*;

   // Opcodes outside the enum; the block must leave all state alone for these.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int PHASE_ITEMS    = 500;
   localparam int LONG_HOLD      = 120;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {
      PH_RECV_SLOW,
      PH_SEND_SLOW,
      PH_FREE
   } phase_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   phase_type phase = PH_RECV_SLOW;

   req_type pending_ops[$];
   rsp_type expected_results[$];

   // Shadow copy of the architectural state
   logic [31:0] gpr_shadow[REG_COUNT];
   logic        flag_m_shadow;
   logic        flag_q_shadow;
   logic        flag_t_shadow;

   int mismatch_count = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int quiet_cycles   = 0;

   nonrestoring_division_step_unit_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Execute one operation on the shadow state and return Rn and the flags afterwards.
   function automatic rsp_type exec_division_op(input req_type op);
      int          n;
      int          m;
      logic [31:0] shifted;
      logic [31:0] divisor;
      logic [31:0] sum;
      logic        old_q;
      logic        q1;
      logic        cb;
      rsp_type     res;
      n = op.reg_n % REG_COUNT;
      m = op.reg_m % REG_COUNT;
      case (op.opcode)
         OP_WRITE: gpr_shadow[n] = op.write_value;
         OP_DIV0U: begin
            flag_m_shadow = 1'b0;
            flag_q_shadow = 1'b0;
            flag_t_shadow = 1'b0;
         end
         OP_DIV0S: begin
            flag_q_shadow = gpr_shadow[n][31];
            flag_m_shadow = gpr_shadow[m][31];
            flag_t_shadow = flag_q_shadow ^ flag_m_shadow;
         end
         OP_DIV1: begin
            old_q = flag_q_shadow;
            q1 = gpr_shadow[n][31];
            shifted = {gpr_shadow[n][30:0], flag_t_shadow};
            gpr_shadow[n] = shifted;
            // read Rm after the shift so that Rn == Rm sees the shifted value
            divisor = gpr_shadow[m];
            if (old_q == flag_m_shadow) begin
               {cb, sum} = {1'b0, shifted} - {1'b0, divisor};
            end else begin
               {cb, sum} = {1'b0, shifted} + {1'b0, divisor};
            end
            gpr_shadow[n] = sum;
            flag_q_shadow = q1 ^ cb ^ flag_m_shadow;
            flag_t_shadow = (flag_q_shadow == flag_m_shadow);
         end
         OP_ROTL: begin
            flag_t_shadow = gpr_shadow[n][31];
            gpr_shadow[n] = {gpr_shadow[n][30:0], gpr_shadow[n][31]};
         end
         default: ;
      endcase
      res.reg_value = gpr_shadow[n];
      res.m_bit = flag_m_shadow;
      res.q_bit = flag_q_shadow;
      res.t_bit = flag_t_shadow;
      return res;
   endfunction

   function automatic void add_op(input logic [2:0] opc, input logic [3:0] n,
                                  input logic [3:0] m, input logic [31:0] value);
      req_type op;
      op.opcode = opc;
      op.reg_n = n;
      op.reg_m = m;
      op.write_value = value;
      pending_ops.push_back(op);
   endfunction

   // Bias words toward the sign bit, zero, all ones and small divisors.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'($urandom_range(1, 300));
         4: return $urandom() & 32'h0000_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Load dividend and divisor, set up flags, run DIV1 steps with some ROTL, then a READ.
   function automatic int queue_division_run();
      logic [3:0] dividend_reg;
      logic [3:0] divisor_reg;
      logic [3:0] quot_reg;
      int         steps;
      int         added;
      dividend_reg = 4'($urandom_range(0, 15));
      divisor_reg = ($urandom_range(0, 9) == 0) ? dividend_reg : 4'($urandom_range(0, 15));
      quot_reg = 4'($urandom_range(0, 15));
      steps = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 24);
      add_op(OP_WRITE, dividend_reg, 4'($urandom_range(0, 15)), pick_word());
      add_op(OP_WRITE, divisor_reg, 4'($urandom_range(0, 15)), pick_word());
      if ($urandom_range(0, 1) == 0) begin
         add_op(OP_DIV0S, dividend_reg, divisor_reg, $urandom());
      end else begin
         add_op(OP_DIV0U, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom());
      end
      added = 3;
      for (int i = 0; i < steps; i++) begin
         add_op(OP_DIV1, dividend_reg, divisor_reg, $urandom());
         added++;
         if ($urandom_range(0, 3) == 0) begin
            add_op(OP_ROTL, quot_reg, 4'($urandom_range(0, 15)), $urandom());
            added++;
         end
      end
      add_op(OP_READ, dividend_reg, divisor_reg, $urandom());
      return added + 1;
   endfunction

   function automatic void queue_phase(input int target);
      int added;
      added = 0;
      while (added < target) begin
         if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 4; i++) begin
               add_op(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), pick_word());
            end
            added += 4;
         end else begin
            added += queue_division_run();
         end
      end
   endfunction

   function automatic void queue_directed();
      add_op(OP_READ,  4'd0,  4'd15, 32'hFFFF_FFFF);
      add_op(OP_READ,  4'd15, 4'd0,  32'h0000_0000);
      add_op(OP_WRITE, 4'd0,  4'd0,  32'hFFFF_FFFF);
      add_op(OP_WRITE, 4'd15, 4'd15, 32'h8000_0000);
      add_op(OP_WRITE, 4'd1,  4'd2,  32'h0000_0001);
      add_op(OP_WRITE, 4'd2,  4'd1,  32'h0000_0000);
      add_op(OP_WRITE, 4'd3,  4'd0,  32'h7FFF_FFFF);
      add_op(OP_DIV0S, 4'd0,  4'd15, 32'h0000_0000);
      // Rn same as Rm
      add_op(OP_DIV1,  4'd15, 4'd15, 32'h0000_0000);
      add_op(OP_ROTL,  4'd15, 4'd0,  32'h0000_0000);
      add_op(OP_ROTL,  4'd0,  4'd0,  32'h0000_0000);
      add_op(OP_DIV0U, 4'd15, 4'd15, 32'hFFFF_FFFF);
      add_op(OP_DIV1,  4'd0,  4'd1,  32'h0000_0000);
      add_op(OP_SPARE_6, 4'd0,  4'd15, 32'hFFFF_FFFF);
      add_op(OP_SPARE_7, 4'd15, 4'd0,  32'h0000_0000);
      add_op(OP_DIV0S, 4'd1,  4'd2,  32'h0000_0000);
      // divide by zero
      add_op(OP_DIV1,  4'd1,  4'd2,  32'h0000_0000);
      // Q differs from M: add path
      add_op(OP_DIV0S, 4'd3,  4'd0,  32'h0000_0000);
      add_op(OP_DIV1,  4'd3,  4'd0,  32'h0000_0000);
      add_op(OP_DIV1,  4'd3,  4'd0,  32'h0000_0000);
      add_op(OP_READ,  4'd2,  4'd3,  32'h0000_0000);
      add_op(OP_READ,  4'd3,  4'd2,  32'h0000_0000);
   endfunction

   function automatic int send_idle_pct(input phase_type ph);
      case (ph)
         PH_RECV_SLOW: return 14;
         PH_SEND_SLOW: return 82;
         default:      return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct(input phase_type ph);
      case (ph)
         PH_RECV_SLOW: return 82;
         PH_SEND_SLOW: return 14;
         default:      return 0;
      endcase
   endfunction

   // Request driver: predict on each transfer, then offer the next pending operation.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(exec_division_op(req_payload));
         end
         if (!req_valid || req_ready) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(phase)) begin
               req_payload <= pending_ops.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver back-pressure.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: result with nothing expected: value %h m %b q %b t %b",
                           $realtime, rsp_payload.reg_value, rsp_payload.m_bit,
                           rsp_payload.q_bit, rsp_payload.t_bit);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.reg_value !== want.reg_value ||
                   rsp_payload.m_bit !== want.m_bit ||
                   rsp_payload.q_bit !== want.q_bit ||
                   rsp_payload.t_bit !== want.t_bit) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch: value %h/%h m %b/%b q %b/%b t %b/%b (exp/act)",
                              $realtime, want.reg_value, rsp_payload.reg_value,
                              want.m_bit, rsp_payload.m_bit, want.q_bit, rsp_payload.q_bit,
                              want.t_bit, rsp_payload.t_bit);
                  end
               end
            end
         end
         // hold off once for a long stretch so the pipeline backs up into the request side
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (phase == PH_FREE && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct(phase));
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < REG_COUNT; i++) begin
         gpr_shadow[i] = 32'h0;
      end
      flag_m_shadow = 1'b0;
      flag_q_shadow = 1'b0;
      flag_t_shadow = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_directed();
      queue_phase(PHASE_ITEMS);
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      phase = PH_SEND_SLOW;
      queue_phase(PHASE_ITEMS);
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      phase = PH_FREE;
      queue_phase(PHASE_ITEMS);
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         mismatch_count++;
         $display("%0d results never arrived", expected_results.size());
      end
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
